### rtl/core/dpc_pkg.sv
// Shared types and codes for the duplicate packet cache.
package dpc_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_RECORD = 2'd1,
		OP_SWEEP  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [15:0] source_id;
		logic [31:0] packet_id;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic feed_en;
	} chain_ctl_t;

	localparam logic [31:0] MEM_TIME_RESET = 32'd300000;

endpackage

### rtl/core/duplicate_packet_cache_top.sv
// Duplicate packet cache: control sequencer and chain of entry cells.
//
//  channel   signals                                      transaction at edge
//  -------   -------------------------------------------  ---------------------
//  command   start, busy, op, source_id, packet_id,       start & !busy
//            now_ms
//  result    done, seen, entry_count                      done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data               cfg_valid & cfg_ready
//
//  Record and the unused op code: done is registered from ST_EXEC, after accept.
//  Lookup and sweep: ST_EXEC, then ST_SCAN once per stored entry; the chain rotates one
//  entry per cycle past the compare logic at cell 0.
//  busy is high from accept until the result cycle; one command at a time.
//  Reset clears the count and control; entry contents are undefined.
//  The receiver cannot stall; done lasts one cycle.
module duplicate_packet_cache_top import dpc_pkg::*; #(
	parameter int ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] source_id,
	input  logic [31:0] packet_id,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic        seen,
	output logic [5:0]  entry_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t          state_q, state_d;
	op_t             op_q;
	entry_t          new_q;
	logic [31:0]     mem_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   fill_m1;
	logic            hit_q;
	logic            done_q;
	logic            seen_q;
	logic            full;
	logic            match;
	logic            drop;
	logic [31:0]     age;
	logic [CW+5:0]   cnt_ext;
	chain_ctl_t      ctl;
	logic [IDXW-1:0] tail;
	entry_t          feed;
	entry_t          ents [ENTRIES];

	assign full    = (fill_q == CW'(ENTRIES));
	assign fill_m1 = fill_q - CW'(1);
	assign match   = (ents[0].source_id == new_q.source_id) &&
	                 (ents[0].packet_id == new_q.packet_id);
	assign age     = new_q.stamp - ents[0].stamp;
	assign drop    = (op_q == OP_SWEEP) && (age > mem_q);

	// next state and chain control
	always_comb begin
		state_d     = state_q;
		ctl.shift   = 1'b0;
		ctl.feed_en = 1'b0;
		tail        = fill_m1[IDXW-1:0];
		feed        = ents[0];
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				if (op_q == OP_RECORD) begin
					ctl.feed_en = 1'b1;
					feed        = new_q;
					if (full) begin
						ctl.shift = 1'b1;
						tail      = IDXW'(ENTRIES - 1);
					end else begin
						tail = fill_q[IDXW-1:0];
					end
				end else if ((op_q == OP_LOOKUP || op_q == OP_SWEEP) &&
				             fill_q != '0) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.shift   = 1'b1;
				ctl.feed_en = !drop;
				if (rem_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rem_q  <= '0;
			hit_q  <= 1'b0;
			done_q <= 1'b0;
			seen_q <= 1'b0;
			mem_q  <= MEM_TIME_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				mem_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_EXEC: begin
					hit_q <= 1'b0;
					rem_q <= fill_q;
					if (state_d == ST_IDLE) begin
						done_q <= 1'b1;
						seen_q <= 1'b0;
						if (op_q == OP_RECORD && !full) begin
							fill_q <= fill_q + CW'(1);
						end
					end
				end
				ST_SCAN: begin
					rem_q <= rem_q - CW'(1);
					if (drop) begin
						fill_q <= fill_m1;
					end
					if (match) begin
						hit_q <= 1'b1;
					end
					if (rem_q == CW'(1)) begin
						done_q <= 1'b1;
						seen_q <= (op_q == OP_LOOKUP) && (hit_q || match);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q            <= op_t'(op);
			new_q.source_id <= source_id;
			new_q.packet_id <= packet_id;
			new_q.stamp     <= now_ms;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		entry_t nxt;
		if (i == ENTRIES - 1) begin : g_last
			assign nxt = feed;
		end else begin : g_mid
			assign nxt = ents[i+1];
		end
		dpc_cell #(
			.IDXW  (IDXW),
			.INDEX (i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.tail (tail),
			.nxt  (nxt),
			.feed (feed),
			.ent  (ents[i])
		);
	end

	assign cnt_ext     = {6'b0, fill_q};
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign seen        = seen_q;
	assign entry_count = cnt_ext[5:0];
	assign cfg_ready   = 1'b1;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ENTRIES))
		else $error("fill count above capacity");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_EXEC))
		else $error("accepted command not executed");

	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rem_q != '0 && rem_q <= fill_q))
		else $error("scan counter out of range");

	a_seen_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && seen_q) |-> (op_q == OP_LOOKUP))
		else $error("seen set on a non-lookup result");

endmodule

### rtl/core/dpc_cell.sv
// One storage cell of the entry chain.
module dpc_cell import dpc_pkg::*; #(
	parameter int IDXW  = 5,
	parameter int INDEX = 0
) (
	input  logic            clk,
	input  chain_ctl_t      ctl,
	input  logic [IDXW-1:0] tail,
	input  entry_t          nxt,
	input  entry_t          feed,
	output entry_t          ent
);

	localparam logic [IDXW-1:0] IDX = IDXW'(INDEX);

	entry_t ent_q;

	always_ff @(posedge clk) begin
		if (ctl.shift && (IDX < tail)) begin
			ent_q <= nxt;
		end else if (ctl.feed_en && (IDX == tail)) begin
			ent_q <= feed;
		end
	end

	assign ent = ent_q;

endmodule
